/* rtl/core/sdq_pkg.sv */
// Shared types and constants for the single-wire bus master.
// Holds the item structs, the phase and command codes and the bus timing figures.
// No dependencies.
package sdq_pkg;

  localparam int unsigned TickW = 10;

  // Command codes carried in the mode field.
  localparam logic [1:0] MODE_TICK  = 2'd0;
  localparam logic [1:0] MODE_RESET = 2'd1;
  localparam logic [1:0] MODE_WRITE = 2'd2;
  localparam logic [1:0] MODE_READ  = 2'd3;

  // Configuration register indexes.
  localparam logic CFG_READ_SAMPLE_DELAY = 1'b0;
  localparam logic CFG_PRESENCE_POLLS    = 1'b1;

  localparam logic [7:0] READ_SAMPLE_DELAY_RST = 8'd5;
  localparam logic [7:0] PRESENCE_POLLS_RST    = 8'd50;

  // Bus timing in ticks.
  localparam logic [TickW-1:0] RS_LOW_TICKS   = 10'd800;
  localparam logic [TickW-1:0] RS_REL_TICKS   = 10'd60;
  localparam logic [TickW-1:0] REC_TICKS      = 10'd200;
  localparam logic [TickW-1:0] WR_ONE_LOW     = 10'd14;
  localparam logic [TickW-1:0] WR_ZERO_LOW    = 10'd104;
  localparam logic [TickW-1:0] WR_ONE_HIGH    = 10'd107;
  localparam logic [TickW-1:0] WR_ZERO_HIGH   = 10'd17;
  localparam logic [TickW-1:0] RD_LOW_TICKS   = 10'd7;
  localparam logic [TickW-1:0] RD_TAIL_TICKS  = 10'd65;
  localparam logic [3:0]       BITS_PER_BYTE  = 4'd8;

  typedef enum logic [10:0] {
    PH_IDLE    = 11'b000_0000_0001,
    PH_RS_LOW  = 11'b000_0000_0010,
    PH_RS_REL  = 11'b000_0000_0100,
    PH_RS_POLL = 11'b000_0000_1000,
    PH_RS_REC  = 11'b000_0001_0000,
    PH_WR_LOW  = 11'b000_0010_0000,
    PH_WR_HIGH = 11'b000_0100_0000,
    PH_RD_LOW  = 11'b000_1000_0000,
    PH_RD_WAIT = 11'b001_0000_0000,
    PH_RD_TAIL = 11'b010_0000_0000,
    PH_RD_REC  = 11'b100_0000_0000
  } phase_e;

  typedef struct packed {
    logic [1:0] mode;
    logic [7:0] tx_byte;
    logic       line_level;
  } in_item_t;

  typedef struct packed {
    logic       drive_low;
    logic       busy_res;
    logic       done_res;
    logic       presence;
    logic [7:0] rx_byte;
  } out_item_t;

  typedef struct packed {
    logic valid;
    logic idx;
    logic [7:0] data;
  } cfg_wr_t;

endpackage

/* rtl/core/sdq_single_wire_master_top.sv */
// Single-wire bus master: an accepted item passes the input and result registers.
// One item per cycle without output stall; sequencer phase and counters update once per item.
// The input stall follows the output stall combinationally through the result register.
// Reset is asynchronous, active low: idle phase, counters and shift registers cleared,
// sample delay 5 and presence polls 50. Depends on sdq_pkg and the three stage modules.
module sdq_single_wire_master_top (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  sdq_pkg::in_item_t  in_item_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output sdq_pkg::out_item_t out_item_o,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic               cfg_index_i,
  input  logic [7:0]         cfg_data_i
);
  import sdq_pkg::*;

  logic      advance;
  logic      item_valid;
  in_item_t  item;
  out_item_t result;
  cfg_wr_t   cfg;

  assign cfg_ready_o = 1'b1;
  assign cfg.valid   = cfg_valid_i & cfg_ready_o;
  assign cfg.idx     = cfg_index_i;
  assign cfg.data    = cfg_data_i;

  sdq_in_stage u_in (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_item_i   (in_item_i),
    .advance_i   (advance),
    .item_valid_o(item_valid),
    .item_o      (item)
  );

  sdq_ctrl u_ctrl (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .cfg_i    (cfg),
    .advance_i(advance),
    .item_i   (item),
    .result_o (result)
  );

  sdq_out_stage u_out (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .item_valid_i(item_valid),
    .result_i    (result),
    .advance_o   (advance),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_item_o  (out_item_o)
  );

endmodule

/* rtl/core/sdq_in_stage.sv */
// Input register of the bus master: holds one accepted item for the processing stage.
// Depends on sdq_pkg.
module sdq_in_stage (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  sdq_pkg::in_item_t in_item_i,
  input  logic              advance_i,
  output logic              item_valid_o,
  output sdq_pkg::in_item_t item_o
);
  import sdq_pkg::*;

  logic     valid_q, valid_d;
  in_item_t item_q;
  logic     load;

  // The register frees itself in the same cycle that its item moves on.
  assign in_stall_o = valid_q & ~advance_i;
  assign load       = in_valid_i & ~in_stall_o;
  assign valid_d    = load | (valid_q & ~advance_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      item_q <= in_item_i;
    end
  end

  assign item_valid_o = valid_q;
  assign item_o       = item_q;

endmodule

/* rtl/core/sdq_ctrl.sv */
// Bus sequencer: phase, tick and bit counters, shift registers and configuration.
// Steps once for each item handed on by the input register. Depends on sdq_pkg.
module sdq_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  sdq_pkg::cfg_wr_t   cfg_i,
  input  logic               advance_i,
  input  sdq_pkg::in_item_t  item_i,
  output sdq_pkg::out_item_t result_o
);
  import sdq_pkg::*;

  logic [7:0]       sample_delay_q, polls_q;
  phase_e           phase_q, phase_d;
  logic [TickW-1:0] tick_q, tick_d, tick_inc, limit;
  logic [3:0]       bit_q, bit_d, bit_inc;
  logic [7:0]       poll_q, poll_d;
  logic [8:0]       poll_inc, poll_limit;
  logic [7:0]       send_q, send_d;
  logic [7:0]       recv_q, recv_d;
  logic             pres_q, pres_d;
  logic             done;

  assign tick_inc   = tick_q + 10'd1;
  assign bit_inc    = bit_q + 4'd1;
  assign poll_inc   = {1'b0, poll_q} + 9'd1;
  // A poll limit of zero stands for 256 polls.
  assign poll_limit = (polls_q == 8'd0) ? 9'd256 : {1'b0, polls_q};

  always_comb begin
    phase_d = phase_q;
    tick_d  = tick_q;
    bit_d   = bit_q;
    poll_d  = poll_q;
    send_d  = send_q;
    recv_d  = recv_q;
    pres_d  = pres_q;
    done    = 1'b0;
    limit   = '0;
    if (item_i.mode == MODE_TICK) begin
      case (phase_q)
        PH_IDLE: begin
        end
        PH_RS_LOW: begin
          tick_d = tick_inc;
          if (tick_inc >= RS_LOW_TICKS) begin
            phase_d = PH_RS_REL;
            tick_d  = '0;
          end
        end
        PH_RS_REL: begin
          tick_d = tick_inc;
          if (tick_inc >= RS_REL_TICKS) begin
            phase_d = PH_RS_POLL;
            tick_d  = '0;
            poll_d  = '0;
          end
        end
        PH_RS_POLL: begin
          if (!item_i.line_level) begin
            pres_d  = 1'b1;
            phase_d = PH_RS_REC;
            tick_d  = '0;
          end else begin
            poll_d = poll_inc[7:0];
            if (poll_inc >= poll_limit) begin
              phase_d = PH_RS_REC;
              tick_d  = '0;
            end
          end
        end
        PH_RS_REC, PH_RD_REC: begin
          tick_d = tick_inc;
          if (tick_inc >= REC_TICKS) begin
            phase_d = PH_IDLE;
            tick_d  = '0;
            done    = 1'b1;
          end
        end
        PH_WR_LOW: begin
          limit  = send_q[0] ? WR_ONE_LOW : WR_ZERO_LOW;
          tick_d = tick_inc;
          if (tick_inc >= limit) begin
            phase_d = PH_WR_HIGH;
            tick_d  = '0;
          end
        end
        PH_WR_HIGH: begin
          limit  = send_q[0] ? WR_ONE_HIGH : WR_ZERO_HIGH;
          tick_d = tick_inc;
          if (tick_inc >= limit) begin
            send_d = {1'b0, send_q[7:1]};
            bit_d  = bit_inc;
            tick_d = '0;
            if (bit_inc >= BITS_PER_BYTE) begin
              phase_d = PH_IDLE;
              done    = 1'b1;
            end else begin
              phase_d = PH_WR_LOW;
            end
          end
        end
        PH_RD_LOW: begin
          tick_d = tick_inc;
          if (tick_inc >= RD_LOW_TICKS) begin
            tick_d  = '0;
            phase_d = (sample_delay_q == 8'd0) ? PH_RD_TAIL : PH_RD_WAIT;
          end
        end
        PH_RD_WAIT: begin
          tick_d = tick_inc;
          if (tick_inc >= {2'b00, sample_delay_q}) begin
            phase_d = PH_RD_TAIL;
            tick_d  = '0;
          end
        end
        PH_RD_TAIL: begin
          // The line is sampled on the first tick of the tail.
          if (tick_q == '0) begin
            recv_d = recv_q | ({7'd0, item_i.line_level} << bit_q[2:0]);
          end
          tick_d = tick_inc;
          if (tick_inc >= RD_TAIL_TICKS) begin
            bit_d   = bit_inc;
            tick_d  = '0;
            phase_d = (bit_inc >= BITS_PER_BYTE) ? PH_RD_REC : PH_RD_LOW;
          end
        end
        default: begin
          phase_d = PH_IDLE;
          tick_d  = '0;
        end
      endcase
    end else if (phase_q == PH_IDLE) begin
      bit_d  = '0;
      poll_d = '0;
      tick_d = '0;
      case (item_i.mode)
        MODE_RESET: begin
          pres_d  = 1'b0;
          phase_d = PH_RS_LOW;
        end
        MODE_WRITE: begin
          send_d  = item_i.tx_byte;
          phase_d = PH_WR_LOW;
        end
        default: begin
          recv_d  = '0;
          phase_d = PH_RD_LOW;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sample_delay_q <= READ_SAMPLE_DELAY_RST;
      polls_q        <= PRESENCE_POLLS_RST;
      phase_q        <= PH_IDLE;
      tick_q         <= '0;
      bit_q          <= '0;
      poll_q         <= '0;
      send_q         <= '0;
      recv_q         <= '0;
      pres_q         <= 1'b0;
    end else begin
      if (cfg_i.valid) begin
        case (cfg_i.idx)
          CFG_READ_SAMPLE_DELAY: sample_delay_q <= cfg_i.data;
          CFG_PRESENCE_POLLS:    polls_q        <= cfg_i.data;
          default: begin
          end
        endcase
      end
      if (advance_i) begin
        phase_q <= phase_d;
        tick_q  <= tick_d;
        bit_q   <= bit_d;
        poll_q  <= poll_d;
        send_q  <= send_d;
        recv_q  <= recv_d;
        pres_q  <= pres_d;
      end
    end
  end

  assign result_o.drive_low = (phase_d == PH_RS_LOW) | (phase_d == PH_WR_LOW)
                            | (phase_d == PH_RD_LOW);
  assign result_o.busy_res  = (phase_d != PH_IDLE);
  assign result_o.done_res  = done;
  assign result_o.presence  = pres_d;
  assign result_o.rx_byte   = recv_d;

endmodule

/* rtl/core/sdq_out_stage.sv */
// Result register of the bus master: holds one result item until it is taken.
// Depends on sdq_pkg.
module sdq_out_stage (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               item_valid_i,
  input  sdq_pkg::out_item_t result_i,
  output logic               advance_o,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output sdq_pkg::out_item_t out_item_o
);
  import sdq_pkg::*;

  logic      valid_q;
  out_item_t item_q;

  // A new result may enter whenever the register is empty or being emptied.
  assign advance_o = item_valid_i & (~valid_q | ~out_stall_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (advance_o) begin
      valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance_o) begin
      item_q <= result_i;
    end
  end

  assign out_valid_o = valid_q;
  assign out_item_o  = item_q;

endmodule
